FILE: src/rpa_pkg.sv
// Package for the reference-counted page allocator: operation and error codes,
// configuration register indexes, and the command and status types between controller and datapath.
// Has no dependencies; every other file imports it.
package rpa_pkg;

    // Request operation codes
    typedef enum logic [2:0] {
        OP_SEED   = 3'd0,
        OP_ALLOC  = 3'd1,
        OP_FREE   = 3'd2,
        OP_INCREF = 3'd3,
        OP_DECREF = 3'd4,
        OP_READ   = 3'd5
    } t_op;

    // Result error codes
    typedef enum logic [2:0] {
        ERR_OK    = 3'd0,
        ERR_RANGE = 3'd1,
        ERR_OOM   = 3'd2,
        ERR_FULL  = 3'd3,
        ERR_COUNT = 3'd4
    } t_err;

    // Configuration register indexes
    localparam logic CFG_FIRST_PAGE = 1'b0;
    localparam logic CFG_PAGE_LIMIT = 1'b1;

    // Field widths fixed by the interface
    localparam int PAGE_W   = 16;
    localparam int LIMIT_W  = 17;
    localparam int CNT_OUT_W = 8;
    localparam int FREE_W   = 17;

    // Controller state
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic clear;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic clr_last;
    } t_dp_sts;

endpackage

FILE: src/rpa_ctrl.sv
// Controller state machine of the page allocator: clearing pass, idle and execute.
// Depends on rpa_pkg for the state and command types.
module rpa_ctrl
    import rpa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_start,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    o_busy
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            ST_IDLE: begin
                o_busy       = 1'b0;
                o_cmd.accept = i_start;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

FILE: src/rpa_dp.sv
// Datapath of the page allocator: configuration registers, free stack memory,
// reference count memory with its clearing counter, and the result registers.
// Depends on rpa_pkg for codes and the command and status types.
module rpa_dp
    import rpa_pkg::*;
#(
    parameter int NUM_PAGES  = 65536,
    parameter int COUNT_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic [2:0]           i_op,
    input  logic [PAGE_W-1:0]    i_page,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [LIMIT_W-1:0]   i_cfg_data,
    output logic                 o_done,
    output logic [PAGE_W-1:0]    o_alloc_page,
    output logic                 o_alloc_valid,
    output logic [CNT_OUT_W-1:0] o_ref_count,
    output logic [FREE_W-1:0]    o_free_pages,
    output logic [2:0]           o_error
);

    localparam int AW = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
    localparam int DW = $clog2(NUM_PAGES + 1);
    localparam int XW = (AW + 1 > LIMIT_W) ? AW + 1 : LIMIT_W;
    localparam logic [XW-1:0] NP_X = XW'(NUM_PAGES);
    localparam logic [DW-1:0] DEPTH_FULL = DW'(NUM_PAGES);
    localparam logic [AW-1:0] CLR_LAST = AW'(NUM_PAGES - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

    // Memories
    logic [PAGE_W-1:0]     r_stack   [NUM_PAGES];
    logic [COUNT_BITS-1:0] r_ref_mem [NUM_PAGES];

    // Control and configuration registers
    logic [PAGE_W-1:0]  r_first_page;
    logic [LIMIT_W-1:0] r_page_limit;
    logic [DW-1:0]      r_depth;
    logic [DW-1:0]      n_depth;
    logic [AW-1:0]      r_clr_addr;
    logic               r_done;

    // Captured request and read data
    t_op                   r_op;
    logic [PAGE_W-1:0]     r_page;
    logic [PAGE_W-1:0]     r_stk_rd;
    logic [COUNT_BITS-1:0] r_ref_rd;

    // Result registers
    logic [PAGE_W-1:0]     r_alloc_page;
    logic                  r_alloc_valid;
    logic [COUNT_BITS-1:0] r_count;
    t_err                  r_err;

    // Execute-cycle combinational values
    logic [PAGE_W-1:0]     n_alloc_page;
    logic                  n_alloc_valid;
    logic [COUNT_BITS-1:0] n_count;
    t_err                  n_err;
    logic                  w_ref_we;
    logic [AW-1:0]         w_ref_wa;
    logic [COUNT_BITS-1:0] w_ref_wd;
    logic                  w_stk_we;
    logic [COUNT_BITS-1:0] w_cnt;
    logic                  w_page_ok;
    logic                  w_full;

    // Zero-extended forms for range checks and memory addressing
    logic [XW-1:0]      w_in_page_x;
    logic [XW-1:0]      w_page_x;
    logic [XW-1:0]      w_pop_x;
    logic [DW-1:0]      w_pop_idx;
    logic [CNT_OUT_W+COUNT_BITS-1:0] w_cnt_x;
    logic [FREE_W+DW-1:0]            w_depth_x;

    assign w_in_page_x = {{(XW-PAGE_W){1'b0}}, i_page};
    assign w_page_x    = {{(XW-PAGE_W){1'b0}}, r_page};
    assign w_pop_x     = {{(XW-PAGE_W){1'b0}}, r_stk_rd};
    assign w_pop_idx   = r_depth - DW'(1);
    assign w_full      = (r_depth == DEPTH_FULL);
    assign w_page_ok   = (w_page_x >= {{(XW-PAGE_W){1'b0}}, r_first_page})
                      && (w_page_x <  {{(XW-LIMIT_W){1'b0}}, r_page_limit})
                      && (w_page_x <  NP_X);

    // Configuration writes are taken at any time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_page <= '0;
            r_page_limit <= LIMIT_W'(65536);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIRST_PAGE: r_first_page <= i_cfg_data[PAGE_W-1:0];
                CFG_PAGE_LIMIT: r_page_limit <= i_cfg_data;
                default:        r_page_limit <= r_page_limit;
            endcase
        end
    end

    // Clearing pass over the reference count memory after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    assign o_sts.clr_last = (r_clr_addr == CLR_LAST);

    // Capture the request and read both memories when a transaction is accepted
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= t_op'(i_op);
            r_page   <= i_page;
            r_stk_rd <= r_stack[w_pop_idx[AW-1:0]];
            r_ref_rd <= r_ref_mem[w_in_page_x[AW-1:0]];
        end
    end

    // Execute the operation on the captured request
    always_comb begin
        n_alloc_page  = '0;
        n_alloc_valid = 1'b0;
        n_count       = '0;
        n_err         = ERR_OK;
        n_depth       = r_depth;
        w_ref_we      = 1'b0;
        w_ref_wa      = w_page_x[AW-1:0];
        w_ref_wd      = '0;
        w_stk_we      = 1'b0;
        w_cnt         = r_ref_rd;
        unique case (r_op)
            OP_ALLOC: begin
                if (r_depth == '0) begin
                    n_err = ERR_OOM;
                end else begin
                    n_depth       = w_pop_idx;
                    n_alloc_page  = r_stk_rd;
                    n_alloc_valid = 1'b1;
                    n_count       = COUNT_ONE;
                    w_ref_wa      = w_pop_x[AW-1:0];
                    w_ref_wd      = COUNT_ONE;
                    w_ref_we      = (w_pop_x < NP_X);
                end
            end
            OP_SEED, OP_FREE, OP_INCREF, OP_DECREF, OP_READ: begin
                if (!w_page_ok) begin
                    n_err = ERR_RANGE;
                end else begin
                    unique case (r_op)
                        OP_SEED: begin
                            w_cnt = '0;
                        end
                        OP_FREE: begin
                            if (r_ref_rd != '0) begin
                                w_cnt = r_ref_rd - COUNT_ONE;
                            end
                        end
                        OP_INCREF: begin
                            if (r_ref_rd == COUNT_MAX) begin
                                n_err = ERR_COUNT;
                            end else begin
                                w_cnt = r_ref_rd + COUNT_ONE;
                            end
                        end
                        OP_DECREF: begin
                            if (r_ref_rd == '0) begin
                                n_err = ERR_COUNT;
                            end else begin
                                w_cnt = r_ref_rd - COUNT_ONE;
                            end
                        end
                        default: begin
                            w_cnt = r_ref_rd;
                        end
                    endcase
                    // Seed and free (once the count is zero) push, or give ERR_FULL if the stack is full
                    if ((r_op == OP_SEED) || ((r_op == OP_FREE) && (w_cnt == '0))) begin
                        if (w_full) begin
                            n_err = ERR_FULL;
                        end else begin
                            w_stk_we = 1'b1;
                            n_depth  = r_depth + DW'(1);
                        end
                    end
                    w_ref_we = 1'b1;
                    w_ref_wd = w_cnt;
                    n_count  = w_cnt;
                end
            end
            default: begin
                n_err = ERR_OK;
            end
        endcase
    end

    // Memory writes: the clearing pass or the execute cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_ref_mem[r_clr_addr] <= '0;
        end else if (i_cmd.exec && w_ref_we) begin
            r_ref_mem[w_ref_wa] <= w_ref_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_stk_we) begin
            r_stack[r_depth[AW-1:0]] <= r_page;
        end
    end

    // Stack depth and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= i_cmd.exec;
            if (i_cmd.exec) begin
                r_depth <= n_depth;
            end
        end
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_alloc_page  <= n_alloc_page;
            r_alloc_valid <= n_alloc_valid;
            r_count       <= n_count;
            r_err         <= n_err;
        end
    end

    assign w_cnt_x   = {{CNT_OUT_W{1'b0}}, r_count};
    assign w_depth_x = {{FREE_W{1'b0}}, r_depth};

    assign o_done        = r_done;
    assign o_alloc_page  = r_alloc_page;
    assign o_alloc_valid = r_alloc_valid;
    assign o_ref_count   = w_cnt_x[CNT_OUT_W-1:0];
    assign o_free_pages  = w_depth_x[FREE_W-1:0];
    assign o_error       = r_err;

endmodule

FILE: src/refcounted_page_allocator_top.sv
// Top level of the reference-counted page allocator: controller plus datapath.
// Depends on rpa_pkg, rpa_ctrl and rpa_dp.
//
//   Channel   Handshake          Payload
//   request   start / busy       i_op, i_page
//   result    o_done (strobe)    o_alloc_page, o_alloc_valid, o_ref_count,
//                                o_free_pages, o_error
//   config    i_cfg_we           i_cfg_idx, i_cfg_data
//
// For each request the memories are read at the accepting edge and
// the operation is executed and written back in the next cycle, through the single
// write port of the reference count memory. The result strobe follows in the cycle
// after, during which busy is already low and a new request may be accepted.
// After reset a clearing pass zeroes every reference count; busy
// stays high until it ends. The receiver cannot stall the results.
module refcounted_page_allocator_top
    import rpa_pkg::*;
#(
    parameter int NUM_PAGES  = 65536,
    parameter int COUNT_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           i_op,
    input  logic [PAGE_W-1:0]    i_page,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [LIMIT_W-1:0]   i_cfg_data,
    output logic                 o_done,
    output logic [PAGE_W-1:0]    o_alloc_page,
    output logic                 o_alloc_valid,
    output logic [CNT_OUT_W-1:0] o_ref_count,
    output logic [FREE_W-1:0]    o_free_pages,
    output logic [2:0]           o_error
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Controller
    rpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // Datapath
    rpa_dp #(
        .NUM_PAGES  (NUM_PAGES),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_op          (i_op),
        .i_page        (i_page),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_done        (o_done),
        .o_alloc_page  (o_alloc_page),
        .o_alloc_valid (o_alloc_valid),
        .o_ref_count   (o_ref_count),
        .o_free_pages  (o_free_pages),
        .o_error       (o_error)
    );

endmodule

FILE: test/refcounted_page_allocator_checker.sv
// Checker for the reference-counted page allocator: watches the request, result and
// configuration channels, predicts every result and compares it with the block's output.
// Depends on rpa_pkg for the operation and error codes, register indexes and field widths.
module refcounted_page_allocator_checker
    import rpa_pkg::*;
#(
    parameter int NUM_PAGES  = 65536,
    parameter int COUNT_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  logic [2:0]           i_op,
    input  logic [PAGE_W-1:0]    i_page,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [LIMIT_W-1:0]   i_cfg_data,
    input  logic                 i_done,
    input  logic [PAGE_W-1:0]    i_alloc_page,
    input  logic                 i_alloc_valid,
    input  logic [CNT_OUT_W-1:0] i_ref_count,
    input  logic [FREE_W-1:0]    i_free_pages,
    input  logic [2:0]           i_error,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);

    localparam int COUNT_MAX = (1 << COUNT_BITS) - 1;

    // One result transaction as the block reports it.
    typedef struct packed {
        logic [PAGE_W-1:0]    alloc_page;
        logic                 alloc_valid;
        logic [CNT_OUT_W-1:0] ref_count;
        logic [FREE_W-1:0]    free_pages;
        logic [2:0]           error;
    } t_alloc_status;

    // Shadow copy of the allocator state and its configuration.
    logic [COUNT_BITS-1:0] page_refs [NUM_PAGES];
    logic [PAGE_W-1:0]     free_list [NUM_PAGES];
    int                    free_depth;
    logic [PAGE_W-1:0]     lowest_page;
    logic [LIMIT_W-1:0]    page_bound;

    t_alloc_status pending_status [$];
    int            fail_count;
    int            checked;

    // Push a page onto the shadow free list; returns 0 when the list is full.
    function automatic bit push_free(input logic [PAGE_W-1:0] pg);
        if (free_depth >= NUM_PAGES) begin
            return 1'b0;
        end
        free_list[free_depth] = pg;
        free_depth++;
        return 1'b1;
    endfunction

    // Apply one request to the shadow state and return the status it should produce.
    function automatic t_alloc_status apply_request(input logic [2:0] op,
                                                    input logic [PAGE_W-1:0] pg);
        t_alloc_status r;
        int            c;
        r       = '0;
        r.error = ERR_OK;
        if (op == OP_ALLOC) begin
            if (free_depth == 0) begin
                r.error = ERR_OOM;
            end else begin
                free_depth--;
                r.alloc_page  = free_list[free_depth];
                r.alloc_valid = 1'b1;
                if (int'(r.alloc_page) < NUM_PAGES) begin
                    page_refs[r.alloc_page] = COUNT_BITS'(1);
                end
                r.ref_count = CNT_OUT_W'(1);
            end
        end else if (op <= OP_READ) begin
            if (!(pg >= lowest_page && {1'b0, pg} < page_bound && int'(pg) < NUM_PAGES)) begin
                r.error = ERR_RANGE;
            end else begin
                c = page_refs[pg];
                case (op)
                    OP_SEED: begin
                        c = 0;
                        if (!push_free(pg)) r.error = ERR_FULL;
                    end
                    OP_FREE: begin
                        if (c > 0) c--;
                        // A page with no references left goes back on the free list.
                        if (c == 0 && !push_free(pg)) r.error = ERR_FULL;
                    end
                    OP_INCREF: begin
                        if (c >= COUNT_MAX) r.error = ERR_COUNT;
                        else c++;
                    end
                    OP_DECREF: begin
                        if (c == 0) r.error = ERR_COUNT;
                        else c--;
                    end
                    default: begin
                    end
                endcase
                page_refs[pg] = COUNT_BITS'(c);
                r.ref_count   = CNT_OUT_W'(c);
            end
        end
        r.free_pages = FREE_W'(free_depth);
        return r;
    endfunction

    // Results are checked before new requests are predicted, so that a result and an
    // acceptance at the same edge keep the queue in order.
    always @(posedge i_clk) begin
        t_alloc_status got;
        t_alloc_status want;
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PAGES; p++) begin
                page_refs[p] = '0;
            end
            free_depth  = 0;
            lowest_page = '0;
            page_bound  = LIMIT_W'(65536);
            pending_status.delete();
            fail_count  = 0;
            checked     = 0;
        end else begin
            if (i_done) begin
                got = '{i_alloc_page, i_alloc_valid, i_ref_count, i_free_pages, i_error};
                if (pending_status.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("[%0t] unexpected result: page %0d valid %0d count %0d free %0d err %0d",
                                 $time, got.alloc_page, got.alloc_valid, got.ref_count,
                                 got.free_pages, got.error);
                    end
                end else begin
                    want = pending_status.pop_front();
                    checked++;
                    if (got.alloc_page !== want.alloc_page || got.alloc_valid !== want.alloc_valid
                        || got.ref_count !== want.ref_count || got.free_pages !== want.free_pages
                        || got.error !== want.error) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("[%0t] mismatch, expected page %0d valid %0d count %0d free %0d err %0d",
                                     $time, want.alloc_page, want.alloc_valid, want.ref_count,
                                     want.free_pages, want.error);
                            $display("[%0t]           actual   page %0d valid %0d count %0d free %0d err %0d",
                                     $time, got.alloc_page, got.alloc_valid, got.ref_count,
                                     got.free_pages, got.error);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_FIRST_PAGE) lowest_page = i_cfg_data[PAGE_W-1:0];
                else page_bound = i_cfg_data;
            end
            if (i_start && !i_busy) begin
                pending_status.push_back(apply_request(i_op, i_page));
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= pending_status.size();
        o_checked    <= checked;
    end

endmodule

FILE: test/refcounted_page_allocator_top_tb.sv
// Testbench top for the reference-counted page allocator: clock, reset, request and
// configuration stimulus, watchdog and verdict. Depends on rpa_pkg, the block itself
// and refcounted_page_allocator_checker, which does all prediction and comparison.
module refcounted_page_allocator_top_tb;
    import rpa_pkg::*;

    localparam int STALL_LIMIT = 300000;
    localparam int COUNT_BITS  = 8;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [2:0]           i_op;
    logic [PAGE_W-1:0]    i_page;
    logic                 i_cfg_we;
    logic                 i_cfg_idx;
    logic [LIMIT_W-1:0]   i_cfg_data;
    logic                 o_done;
    logic [PAGE_W-1:0]    o_alloc_page;
    logic                 o_alloc_valid;
    logic [CNT_OUT_W-1:0] o_ref_count;
    logic [FREE_W-1:0]    o_free_pages;
    logic [2:0]           o_error;

    int fail_count;
    int pending;
    int checked;
    int idle_pct;
    int n_requests;
    int stall_cycles;

    refcounted_page_allocator_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_op         (i_op),
        .i_page       (i_page),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_done       (o_done),
        .o_alloc_page (o_alloc_page),
        .o_alloc_valid(o_alloc_valid),
        .o_ref_count  (o_ref_count),
        .o_free_pages (o_free_pages),
        .o_error      (o_error)
    );

    refcounted_page_allocator_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_op         (i_op),
        .i_page       (i_page),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_done       (o_done),
        .i_alloc_page (o_alloc_page),
        .i_alloc_valid(o_alloc_valid),
        .i_ref_count  (o_ref_count),
        .i_free_pages (o_free_pages),
        .i_error      (o_error),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Clock with a period of four time units.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog expired after %0d idle cycles", stall_cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Present one request and hold it until it is accepted, with a random gap first.
    task automatic issue(input logic [2:0] op, input logic [PAGE_W-1:0] pg);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start  <= 1'b1;
        i_op   <= op;
        i_page <= pg;
        do @(posedge i_clk); while (busy);
        n_requests++;
    endtask

    // Stop requesting and wait until every expected result has come back.
    task automatic settle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both window registers on consecutive cycles.
    task automatic write_window(input logic [PAGE_W-1:0] first, input logic [LIMIT_W-1:0] bound);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FIRST_PAGE;
        i_cfg_data <= {1'b0, first};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_PAGE_LIMIT;
        i_cfg_data <= bound;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Random request: pages mostly from a small pool so that counts and the free list
    // interact, with some noise across the whole page range and the unused op codes.
    task automatic random_request(input int base, input int span);
        logic [2:0]        op;
        logic [PAGE_W-1:0] pg;
        int                pick;
        pick = $urandom_range(99);
        if (pick < 15)      op = OP_SEED;
        else if (pick < 40) op = OP_ALLOC;
        else if (pick < 60) op = OP_FREE;
        else if (pick < 75) op = OP_INCREF;
        else if (pick < 87) op = OP_DECREF;
        else if (pick < 97) op = OP_READ;
        else                op = 3'(OP_READ + 1 + $urandom_range(1));
        if ($urandom_range(9) == 0) pg = PAGE_W'($urandom);
        else pg = PAGE_W'(base + $urandom_range(span - 1));
        issue(op, pg);
    endtask

    // One phase: idle the block, set the window, then run random requests.
    task automatic run_phase(input logic [PAGE_W-1:0] first, input logic [LIMIT_W-1:0] bound,
                             input int base, input int span, input int idle, input int count);
        settle();
        write_window(first, bound);
        idle_pct = idle;
        repeat (count) random_request(base, span);
    endtask

    initial begin
        logic [PAGE_W-1:0] pg;
        start        <= 1'b0;
        i_op         <= OP_SEED;
        i_page       <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_FIRST_PAGE;
        i_cfg_data   <= '0;
        i_rst_n      <= 1'b0;
        idle_pct     = 0;
        n_requests   = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // Let the reference count clearing pass finish.
        repeat (2) @(posedge i_clk);
        while (busy) @(posedge i_clk);

        // Directed: empty list, full-range pages, refcount round trip, double free,
        // decrement at zero and the unused op codes, with the reset window.
        issue(OP_ALLOC, 16'h0000);
        issue(OP_READ, 16'h0000);
        issue(OP_READ, 16'hFFFF);
        issue(OP_SEED, 16'hFFFF);
        issue(OP_SEED, 16'h0000);
        issue(OP_ALLOC, 16'h1234);
        issue(OP_INCREF, 16'h0000);
        issue(OP_DECREF, 16'h0000);
        issue(OP_FREE, 16'h0000);
        issue(OP_FREE, 16'h0000);
        issue(OP_DECREF, 16'hFFFF);
        issue(3'(OP_READ + 1), 16'h5555);
        issue(3'(OP_READ + 2), 16'hAAAA);
        issue(OP_ALLOC, 16'hFFFF);
        issue(OP_ALLOC, 16'h0000);
        issue(OP_ALLOC, 16'h0000);
        issue(OP_ALLOC, 16'h0000);
        // Directed: pages either side of a narrow window.
        settle();
        write_window(16'h0100, 17'h00200);
        issue(OP_READ, 16'h00FF);
        issue(OP_SEED, 16'h0200);
        issue(OP_SEED, 16'h0100);
        issue(OP_INCREF, 16'h0100);
        issue(OP_FREE, 16'h01FF);
        issue(OP_DECREF, 16'h0000);

        // Full window, no idling, with a count driven up to saturation and back below zero.
        run_phase(16'h0000, 17'h10000, 16'h4000 + $urandom_range(255), 24, 0, 80);
        pg = PAGE_W'($urandom);
        issue(OP_SEED, pg);
        repeat (1 << COUNT_BITS) issue(OP_INCREF, pg);
        repeat (1 << COUNT_BITS) issue(OP_DECREF, pg);
        issue(OP_READ, pg);

        run_phase(16'h0100, 17'h00140, 16'h00F8, 80, 54, 50);
        run_phase(16'hFFFF, 17'h10000, 16'hFFFE, 2, 26, 40);
        run_phase(16'h0000, 17'h00001, 0, 2, 54, 40);
        run_phase(16'h8000, 17'h07000, 16'h6FF0, 16'h1020, 0, 20);
        run_phase(16'h1234, 17'h0FEDC, 16'h1230, 32, 26, 50);

        // Full window again: seed, free twice around an incref on one page, then a
        // short random tail over a small pool.
        run_phase(16'h0000, 17'h10000, 0, 16, 0, 0);
        pg = PAGE_W'($urandom);
        issue(OP_SEED, pg);
        issue(OP_FREE, pg);
        issue(OP_INCREF, pg);
        issue(OP_FREE, pg);
        repeat (20) random_request(0, 16);

        settle();
        repeat (16) @(posedge i_clk);
        $display("Summary: %0d request transactions over several page windows, %0d results checked,",
                 n_requests, checked);
        $display("including a count driven to saturation and back below zero.");
        if (fail_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
